@@ rtl/core/ultrasonic_level_ranger_macros.svh @@
// Assertion macros for the ultrasonic level ranger.
// Included by ultrasonic_level_ranger, the RTL file that carries concurrent checks; no other dependencies.
`ifndef ULTRASONIC_LEVEL_RANGER_MACROS_SVH
`define ULTRASONIC_LEVEL_RANGER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge outside reset
`define ULR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ulr check failed: same-cycle implication");

// next-cycle implication
`define ULR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ulr check failed: next-cycle implication");

`else

`define ULR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ULR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/ulr_pkg.sv @@
// Shared types, constants and the microcode table of the ultrasonic level ranger.
// No dependencies; used by ulr_divider and ultrasonic_level_ranger.
`default_nettype none

package ulr_pkg;

  // fixed field widths
  localparam int CFG_TICK_W  = 16;
  localparam int DIST_W      = 11;
  localparam int LEVEL_W     = 7;
  localparam int DIVISOR_W   = 12;
  localparam int LEVEL_NUM_W = 19;
  localparam int S_DATA_W    = 8;
  localparam int M_DATA_W    = 24;
  localparam int PC_W        = 3;

  // sensor timing and scaling
  localparam int TRIG_LOW_TICKS  = 2;
  localparam int TRIG_HIGH_TICKS = 10;
  localparam logic [DIVISOR_W-1:0] US_PER_CM = 12'd58;
  localparam logic [7:0] LEVEL_SCALE = 8'd200;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL_PCT = 7'd100;

  // width / 58 as (width * ceil(2^30 / 58)) >> 30, exact for widths below 2^24;
  // only the low DIST_W quotient bits are kept, so the product is cut there
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 25;
  localparam int DIST_PROD_W = RECIP_SHIFT + DIST_W;
  localparam logic [RECIP_W-1:0] US_PER_CM_RECIP = 25'd18512791;

  // register map (index = paddr[3:2])
  localparam logic [1:0] REG_DIST_EMPTY   = 2'd0;
  localparam logic [1:0] REG_DIST_FULL    = 2'd1;
  localparam logic [1:0] REG_SETTLE       = 2'd2;
  localparam logic [1:0] REG_ECHO_TIMEOUT = 2'd3;

  localparam logic [DIST_W-1:0]     RST_DIST_EMPTY   = 11'd100;
  localparam logic [DIST_W-1:0]     RST_DIST_FULL    = 11'd10;
  localparam logic [CFG_TICK_W-1:0] RST_SETTLE       = 16'd50000;
  localparam logic [CFG_TICK_W-1:0] RST_ECHO_TIMEOUT = 16'd30000;

  // measurement phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_SETTLE = 7'b0000010,
    PH_TLOW   = 7'b0000100,
    PH_THIGH  = 7'b0001000,
    PH_WLOW   = 7'b0010000,
    PH_WHIGH  = 7'b0100000,
    PH_MEAS   = 7'b1000000
  } phase_t;

  // divider control from the microcode
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_NO_INPUT  = 3'd1,
    C_NOT_OK    = 3'd2,
    C_DIV_BUSY  = 3'd3,
    C_LEVEL_SET = 3'd4,
    C_OUT_FREE  = 3'd5,
    C_ALWAYS    = 3'd6
  } cond_t;

  typedef struct packed {
    logic            accept;
    logic            div_load;
    logic            div_step;
    logic            store_dist;
    logic            store_level;
    logic            emit;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // program steps
  localparam logic [PC_W-1:0] STEP_FETCH  = 3'd0;
  localparam logic [PC_W-1:0] STEP_CHECK  = 3'd1;
  localparam logic [PC_W-1:0] STEP_DSTORE = 3'd2;
  localparam logic [PC_W-1:0] STEP_LLOAD  = 3'd3;
  localparam logic [PC_W-1:0] STEP_LSTEP  = 3'd4;
  localparam logic [PC_W-1:0] STEP_LSTORE = 3'd5;
  localparam logic [PC_W-1:0] STEP_EMIT   = 3'd6;
  localparam logic [PC_W-1:0] STEP_HOLD   = 3'd7;

  // microcode table: one control word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      STEP_FETCH: begin
        w.accept = 1'b1;
        w.cond   = C_NO_INPUT;
        w.target = STEP_FETCH;
      end
      STEP_CHECK: begin
        w.cond   = C_NOT_OK;
        w.target = STEP_EMIT;
      end
      STEP_DSTORE: begin
        w.store_dist = 1'b1;
        w.cond       = C_LEVEL_SET;
        w.target     = STEP_EMIT;
      end
      STEP_LLOAD: begin
        w.div_load = 1'b1;
      end
      STEP_LSTEP: begin
        w.div_step = 1'b1;
        w.cond     = C_DIV_BUSY;
        w.target   = STEP_LSTEP;
      end
      STEP_LSTORE: begin
        w.store_level = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_FREE;
        w.target = STEP_FETCH;
      end
      STEP_HOLD: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ulr_divider.sv @@
// Bit-serial restoring divider, one quotient bit per step.
// Depends on ulr_pkg for the divisor width and the control struct.
`default_nettype none

module ulr_divider #(
  parameter int DIVIDEND_W = 19
) (
  input  wire                          clk,
  input  wire                          rst,
  input  ulr_pkg::div_ctl_t            ctl,
  input  wire [DIVIDEND_W-1:0]         dividend,
  input  wire [ulr_pkg::DIVISOR_W-1:0] divisor,
  output logic                         last,
  output logic [DIVIDEND_W-1:0]        quotient
);
  import ulr_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [CW-1:0]        cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   partial;
  logic [DIVISOR_W:0]   diff;

  // trial subtract of the divisor from the shifted remainder
  assign partial = {rem, quotient[DIVIDEND_W-1]};
  assign diff    = partial - {1'b0, divisor};
  assign last    = (cnt == CW'(1));

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= CW'(DIVIDEND_W);
    end else if (ctl.step) begin
      cnt <= cnt - CW'(1);
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (ctl.step) begin
      if (!diff[DIVISOR_W]) begin
        rem      <= diff[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem      <= partial[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ultrasonic_level_ranger.sv @@
// Ultrasonic tank-level ranger. Each input word is one microsecond tick with the
// start request (bit 0) and the sampled echo pin (bit 1); each tick returns one
// output word with power, trigger, busy, done, no-echo, distance in cm and fill
// level in percent. A start in idle powers the sensor, waits settle_ticks, pulses
// the trigger (2 ticks low, 10 high), then times the echo within echo_timeout_ticks.
// A microcoded sequencer handles one tick at a time. An ordinary tick steps
// through fetch, check and output. The tick that completes a good measurement
// gets its distance, width / 58, from a reciprocal multiply in one step and goes
// straight to output when the distance sits at either end of the scale; otherwise
// a one-bit-per-cycle divider first forms the rounded level in 19 steps.
// Output stalls cycle the sequencer between its output and hold steps. Registers
// sit on an APB port at byte addresses 0, 4, 8 and 12.
`default_nettype none

`include "ultrasonic_level_ranger_macros.svh"

module ultrasonic_level_ranger #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  // tick input
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire [ulr_pkg::S_DATA_W-1:0] s_tdata,   // [0] start_req, [1] echo_level
  // result output
  output logic                        m_tvalid,
  input  wire                         m_tready,
  // [0] power_on, [1] trig_out, [2] busy_res, [3] done_res, [4] no_echo,
  // [15:5] distance_cm, [22:16] level_percent
  output logic [ulr_pkg::M_DATA_W-1:0] m_tdata,
  // configuration
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [3:0]                   paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ulr_pkg::*;

  localparam int TW = TICK_COUNT_WIDTH;
  localparam int LW = (TW > CFG_TICK_W) ? TW : CFG_TICK_W;
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  // configuration registers
  logic [DIST_W-1:0]     dist_empty_cm;
  logic [DIST_W-1:0]     dist_full_cm;
  logic [CFG_TICK_W-1:0] settle_ticks;
  logic [CFG_TICK_W-1:0] echo_timeout_ticks;

  // sequencer
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          ctrl;
  logic            take;

  // measurement state
  phase_t            phase;
  phase_t            phase_next;
  logic [TW-1:0]     phase_ticks;
  logic [TW-1:0]     phase_ticks_next;
  logic [TW-1:0]     echo_width;
  logic [TW-1:0]     echo_width_next;
  logic [DIST_W-1:0] distance_store;
  logic [LEVEL_W-1:0] level_store;
  logic              no_echo_store;
  logic              meas_ok;
  logic              meas_ok_next;
  logic              meas_fail_next;
  logic              done_q;

  // tick datapath
  logic          tick_fire;
  logic          start_in;
  logic          echo_in;
  logic [TW-1:0] ticks_inc;
  logic [TW-1:0] width_inc;
  logic [TW-1:0] settle_lim;
  logic [TW-1:0] timeout_lim;

  // distance and level datapath
  logic [DIST_PROD_W-1:0] dist_prod;
  div_ctl_t               div_ctl;
  logic [LEVEL_NUM_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   div_last;
  logic [LEVEL_NUM_W-1:0] div_q;
  logic [DIST_W-1:0]      q_dist;
  logic                   lvl_full;
  logic                   lvl_empty;
  logic [DIST_W-1:0]      lvl_den;
  logic [DIST_W-1:0]      lvl_diff;
  logic [LEVEL_NUM_W-1:0] lvl_num;

  logic out_free;
  logic cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_empty_cm      <= RST_DIST_EMPTY;
      dist_full_cm       <= RST_DIST_FULL;
      settle_ticks       <= RST_SETTLE;
      echo_timeout_ticks <= RST_ECHO_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DIST_EMPTY:   dist_empty_cm      <= pwdata[DIST_W-1:0];
        REG_DIST_FULL:    dist_full_cm       <= pwdata[DIST_W-1:0];
        REG_SETTLE:       settle_ticks       <= pwdata[CFG_TICK_W-1:0];
        REG_ECHO_TIMEOUT: echo_timeout_ticks <= pwdata[CFG_TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      REG_DIST_EMPTY:   prdata = 32'(dist_empty_cm);
      REG_DIST_FULL:    prdata = 32'(dist_full_cm);
      REG_SETTLE:       prdata = 32'(settle_ticks);
      REG_ECHO_TIMEOUT: prdata = 32'(echo_timeout_ticks);
      default:          prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign ctrl     = ucode_rom(pc);
  assign s_tready = ctrl.accept;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (ctrl.cond)
      C_NEXT:      take = 1'b0;
      C_NO_INPUT:  take = !s_tvalid;
      C_NOT_OK:    take = !meas_ok;
      C_DIV_BUSY:  take = !div_last;
      C_LEVEL_SET: take = lvl_full || lvl_empty;
      C_OUT_FREE:  take = out_free;
      C_ALWAYS:    take = 1'b1;
      default:     take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------- tick update ----------------
  assign tick_fire = s_tvalid && s_tready;
  assign start_in  = s_tdata[0];
  assign echo_in   = s_tdata[1];
  assign ticks_inc = (phase_ticks == TICK_MAX) ? phase_ticks : phase_ticks + TW'(1);
  assign width_inc = (echo_width == TICK_MAX) ? echo_width : echo_width + TW'(1);

  // clamp limits to the counter range
  assign settle_lim  = (LW'(settle_ticks) > LW'(TICK_MAX)) ? TICK_MAX : TW'(settle_ticks);
  assign timeout_lim = (LW'(echo_timeout_ticks) > LW'(TICK_MAX)) ? TICK_MAX
                                                                 : TW'(echo_timeout_ticks);

  always_comb begin
    phase_next       = phase;
    phase_ticks_next = phase_ticks;
    echo_width_next  = echo_width;
    meas_ok_next     = 1'b0;
    meas_fail_next   = 1'b0;
    unique case (phase) inside
      PH_IDLE: begin
        if (start_in) begin
          phase_ticks_next = '0;
          phase_next       = (settle_ticks == '0) ? PH_TLOW : PH_SETTLE;
        end
      end
      PH_SETTLE: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= settle_lim) begin
          phase_next       = PH_TLOW;
          phase_ticks_next = '0;
        end
      end
      PH_TLOW: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= TW'(TRIG_LOW_TICKS)) begin
          phase_next       = PH_THIGH;
          phase_ticks_next = '0;
        end
      end
      PH_THIGH: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= TW'(TRIG_HIGH_TICKS)) begin
          phase_next       = PH_WLOW;
          phase_ticks_next = '0;
          echo_width_next  = '0;
        end
      end
      PH_WLOW, PH_WHIGH, PH_MEAS: begin
        phase_ticks_next = ticks_inc;
        if (phase == PH_WLOW) begin
          if (!echo_in) phase_next = PH_WHIGH;
        end else if (phase == PH_WHIGH) begin
          if (echo_in) begin
            phase_next      = PH_MEAS;
            echo_width_next = TW'(1);
          end
        end else begin
          if (echo_in) begin
            echo_width_next = width_inc;
          end else begin
            meas_ok_next = 1'b1;
          end
        end
        // a falling echo wins over the timeout on the same tick
        if (!meas_ok_next && ticks_inc >= timeout_lim) begin
          meas_fail_next = 1'b1;
        end
        if (meas_ok_next || meas_fail_next) begin
          phase_next       = PH_IDLE;
          phase_ticks_next = '0;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        phase_ticks_next = '0;
      end
    endcase
  end

  // ---------------- distance and level operands ----------------
  // width / 58 by reciprocal multiply, low quotient bits only
  assign dist_prod = DIST_PROD_W'(echo_width) * DIST_PROD_W'(US_PER_CM_RECIP);
  assign q_dist    = dist_prod[DIST_PROD_W-1:RECIP_SHIFT];
  assign lvl_full  = (q_dist <= dist_full_cm);
  assign lvl_empty = (q_dist >= dist_empty_cm);
  assign lvl_den   = dist_empty_cm - dist_full_cm;
  assign lvl_diff  = dist_empty_cm - distance_store;
  // 200*(empty-d) + den, rounded-half-up numerator
  assign lvl_num   = LEVEL_NUM_W'(lvl_diff) * LEVEL_NUM_W'(LEVEL_SCALE)
                   + LEVEL_NUM_W'(lvl_den);

  assign div_ctl.load  = ctrl.div_load;
  assign div_ctl.step  = ctrl.div_step;
  assign div_dividend  = lvl_num;
  assign div_divisor   = {lvl_den, 1'b0};

  ulr_divider #(
    .DIVIDEND_W (LEVEL_NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .last     (div_last),
    .quotient (div_q)
  );

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      phase_ticks    <= '0;
      echo_width     <= '0;
      distance_store <= '0;
      level_store    <= '0;
      no_echo_store  <= 1'b0;
      meas_ok        <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      if (tick_fire) begin
        phase       <= phase_next;
        phase_ticks <= phase_ticks_next;
        echo_width  <= echo_width_next;
        meas_ok     <= meas_ok_next;
        done_q      <= meas_ok_next || meas_fail_next;
        if (meas_ok_next) begin
          no_echo_store <= 1'b0;
        end else if (meas_fail_next) begin
          no_echo_store  <= 1'b1;
          distance_store <= '0;
          level_store    <= '0;
        end
      end
      // distance, and level when it sits at either end of the scale
      if (ctrl.store_dist) begin
        distance_store <= q_dist;
        if (lvl_full) begin
          level_store <= LEVEL_FULL_PCT;
        end else if (lvl_empty) begin
          level_store <= '0;
        end
      end
      if (ctrl.store_level) begin
        level_store <= div_q[LEVEL_W-1:0];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      m_tdata <= {1'b0, level_store, distance_store, no_echo_store, done_q,
                  (phase != PH_IDLE), (phase == PH_THIGH), (phase != PH_IDLE)};
    end
  end

  // ---------------- checks ----------------
  `ULR_ASSERT_NEXT(a_accept_check, clk, rst, s_tvalid && s_tready, pc == STEP_CHECK)
  `ULR_ASSERT_NEXT(a_div_stop, clk, rst, ctrl.div_step && div_last, !ctrl.div_step)
  `ULR_ASSERT_IMP(a_level_range, clk, rst, 1'b1, level_store <= LEVEL_FULL_PCT)
  `ULR_ASSERT_IMP(a_done_idle, clk, rst, m_tvalid && m_tdata[3], !m_tdata[0] && !m_tdata[1])

endmodule

`default_nettype wire
